/* rtl/crc8fd_pkg.sv */
package crc8fd_pkg;

  // Frame layout
  localparam int unsigned FrameLength = 11;
  localparam int unsigned PosW = $clog2(FrameLength);

  typedef logic [PosW-1:0] pos_t;

  localparam pos_t POS_START_ONE = pos_t'(0);
  localparam pos_t POS_START_TWO = pos_t'(1);
  localparam pos_t POS_VERSION   = pos_t'(2);
  localparam pos_t POS_TYPE      = pos_t'(3);
  localparam pos_t POS_SEQUENCE  = pos_t'(4);
  localparam pos_t POS_PARAM     = pos_t'(5);
  localparam pos_t POS_VALUE0    = pos_t'(6);
  localparam pos_t POS_VALUE1    = pos_t'(7);
  localparam pos_t POS_VALUE2    = pos_t'(8);
  localparam pos_t POS_VALUE3    = pos_t'(9);
  localparam pos_t POS_CRC       = pos_t'(FrameLength - 1);

  // CRC-8, polynomial x^8 + x^2 + x + 1, MSB first
  localparam logic [7:0] CRC_POLY = 8'h07;
  localparam logic [7:0] CRC_INIT = 8'h00;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_ONE = 2'd0,
    CFG_START_TWO = 2'd1,
    CFG_VERSION   = 2'd2
  } cfg_idx_e;

  // Frame status codes
  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_VERSION = 2'd1,
    STATUS_CRC     = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] start_one;
    logic [7:0] start_two;
    logic [7:0] version;
  } cfg_t;

  // Absorb one byte into the running CRC
  function automatic logic [7:0] crc_absorb(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

/* rtl/crc8fd_cfg.sv */
module crc8fd_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [crc8fd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]                     cfg_data_i,
  output crc8fd_pkg::cfg_t               cfg_o
);

  crc8fd_pkg::cfg_t cfg_q;

  // Write one register per request; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        crc8fd_pkg::CFG_START_ONE: cfg_q.start_one <= cfg_data_i;
        crc8fd_pkg::CFG_START_TWO: cfg_q.start_two <= cfg_data_i;
        crc8fd_pkg::CFG_VERSION:   cfg_q.version   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/crc8fd_in_reg.sv */
module crc8fd_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       stall_o,
  input  logic [7:0] byte_i,
  input  logic       advance_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q;
  logic [7:0] byte_q;

  // Hold the byte while the parser cannot take it
  assign stall_o = valid_q & ~advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !stall_o) begin
      byte_q <= byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

/* rtl/crc8fd_parser.sv */
module crc8fd_parser (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  crc8fd_pkg::cfg_t        cfg_i,
  input  logic                    valid_i,
  input  logic [7:0]              byte_i,
  output logic                    advance_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [1:0]              frame_status_o,
  output logic [7:0]              frame_type_o,
  output logic [7:0]              sequence_number_o,
  output logic [7:0]              param_index_o,
  output logic signed [31:0]      param_value_o,
  output logic [31:0]             good_frame_count_o,
  output logic [31:0]             crc_error_count_o,
  output logic [31:0]             version_error_count_o
);

  crc8fd_pkg::pos_t    pos_q, pos_d;
  logic [7:0]          crc_q, crc_d;
  logic [7:0]          ver_q, ver_d;
  logic [7:0]          type_q, type_d;
  logic [7:0]          seq_q, seq_d;
  logic [7:0]          param_q, param_d;
  logic [31:0]         value_q, value_d;
  logic [31:0]         good_q, good_d;
  logic [31:0]         crc_err_q, crc_err_d;
  logic [31:0]         ver_err_q, ver_err_d;
  crc8fd_pkg::status_e status_d;
  logic                take;
  logic                fire;

  logic                out_valid_q;
  crc8fd_pkg::status_e out_status_q;
  logic [7:0]          out_type_q, out_seq_q, out_param_q;
  logic [31:0]         out_value_q, out_good_q, out_crc_err_q, out_ver_err_q;

  // Advance whenever the result register is free or being drained
  assign advance_o = ~(out_valid_q & out_stall_i);
  assign take      = valid_i & advance_o;

  // Frame state machine with running CRC
  always_comb begin
    pos_d     = pos_q;
    crc_d     = crc_q;
    ver_d     = ver_q;
    type_d    = type_q;
    seq_d     = seq_q;
    param_d   = param_q;
    value_d   = value_q;
    good_d    = good_q;
    crc_err_d = crc_err_q;
    ver_err_d = ver_err_q;
    status_d  = crc8fd_pkg::STATUS_OK;
    fire      = 1'b0;
    if (take) begin
      case (pos_q)
        crc8fd_pkg::POS_START_ONE: begin
          if (byte_i == cfg_i.start_one) pos_d = crc8fd_pkg::POS_START_TWO;
        end
        crc8fd_pkg::POS_START_TWO: begin
          if (byte_i == cfg_i.start_two) begin
            pos_d = crc8fd_pkg::POS_VERSION;
          end else if (byte_i == cfg_i.start_one) begin
            pos_d = crc8fd_pkg::POS_START_TWO;
          end else begin
            pos_d = crc8fd_pkg::POS_START_ONE;
          end
        end
        crc8fd_pkg::POS_VERSION: begin
          ver_d = byte_i;
          crc_d = crc8fd_pkg::crc_absorb(crc8fd_pkg::CRC_INIT, byte_i);
          pos_d = pos_q + crc8fd_pkg::pos_t'(1);
        end
        crc8fd_pkg::POS_TYPE: begin
          type_d = byte_i;
          crc_d  = crc8fd_pkg::crc_absorb(crc_q, byte_i);
          pos_d  = pos_q + crc8fd_pkg::pos_t'(1);
        end
        crc8fd_pkg::POS_SEQUENCE: begin
          seq_d = byte_i;
          crc_d = crc8fd_pkg::crc_absorb(crc_q, byte_i);
          pos_d = pos_q + crc8fd_pkg::pos_t'(1);
        end
        crc8fd_pkg::POS_PARAM: begin
          param_d = byte_i;
          crc_d   = crc8fd_pkg::crc_absorb(crc_q, byte_i);
          pos_d   = pos_q + crc8fd_pkg::pos_t'(1);
        end
        crc8fd_pkg::POS_VALUE0, crc8fd_pkg::POS_VALUE1,
        crc8fd_pkg::POS_VALUE2, crc8fd_pkg::POS_VALUE3: begin
          // Little-endian: shift new bytes in from the top
          value_d = {byte_i, value_q[31:8]};
          crc_d   = crc8fd_pkg::crc_absorb(crc_q, byte_i);
          pos_d   = pos_q + crc8fd_pkg::pos_t'(1);
        end
        crc8fd_pkg::POS_CRC: begin
          fire  = 1'b1;
          pos_d = crc8fd_pkg::POS_START_ONE;
          if (ver_q != cfg_i.version) begin
            status_d  = crc8fd_pkg::STATUS_VERSION;
            ver_err_d = ver_err_q + 32'd1;
          end else if (crc_q != byte_i) begin
            status_d  = crc8fd_pkg::STATUS_CRC;
            crc_err_d = crc_err_q + 32'd1;
          end else begin
            status_d = crc8fd_pkg::STATUS_OK;
            good_d   = good_q + 32'd1;
          end
        end
        default: pos_d = crc8fd_pkg::POS_START_ONE;
      endcase
    end
  end

  // Control state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= crc8fd_pkg::POS_START_ONE;
      good_q      <= '0;
      crc_err_q   <= '0;
      ver_err_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q     <= pos_d;
      good_q    <= good_d;
      crc_err_q <= crc_err_d;
      ver_err_q <= ver_err_d;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Frame payload and result register
  always_ff @(posedge clk_i) begin
    crc_q   <= crc_d;
    ver_q   <= ver_d;
    type_q  <= type_d;
    seq_q   <= seq_d;
    param_q <= param_d;
    value_q <= value_d;
    if (fire) begin
      out_status_q  <= status_d;
      out_type_q    <= type_q;
      out_seq_q     <= seq_q;
      out_param_q   <= param_q;
      out_value_q   <= value_q;
      out_good_q    <= good_d;
      out_crc_err_q <= crc_err_d;
      out_ver_err_q <= ver_err_d;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign frame_status_o        = out_status_q;
  assign frame_type_o          = out_type_q;
  assign sequence_number_o     = out_seq_q;
  assign param_index_o         = out_param_q;
  assign param_value_o         = out_value_q;
  assign good_frame_count_o    = out_good_q;
  assign crc_error_count_o     = out_crc_err_q;
  assign version_error_count_o = out_ver_err_q;

endmodule

/* rtl/crc8_frame_deframer.sv */
// Latency: a result is registered and valid in the cycle after the parser accepts the
// frame's CRC byte; it takes no byte while out_stall_i holds an earlier result.
// Throughput: one byte per cycle when not stalled; the CRC absorbs a byte per cycle.
// An output stall backs up through the byte register into in_stall_o.
// Reset (rst_ni low, asynchronous): hunt restarts, counters and markers clear to zero,
// no result pending.
module crc8_frame_deframer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [crc8fd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]                     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     rx_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [1:0]                     frame_status_o,
  output logic [7:0]                     frame_type_o,
  output logic [7:0]                     sequence_number_o,
  output logic [7:0]                     param_index_o,
  output logic signed [31:0]             param_value_o,
  output logic [31:0]                    good_frame_count_o,
  output logic [31:0]                    crc_error_count_o,
  output logic [31:0]                    version_error_count_o
);

  crc8fd_pkg::cfg_t cfg;
  logic             byte_valid;
  logic [7:0]       byte_data;
  logic             advance;

  crc8fd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  crc8fd_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_valid_i),
    .stall_o   (in_stall_o),
    .byte_i    (rx_byte_i),
    .advance_i (advance),
    .valid_o   (byte_valid),
    .byte_o    (byte_data)
  );

  crc8fd_parser u_parser (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_i                 (cfg),
    .valid_i               (byte_valid),
    .byte_i                (byte_data),
    .advance_o             (advance),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .frame_status_o        (frame_status_o),
    .frame_type_o          (frame_type_o),
    .sequence_number_o     (sequence_number_o),
    .param_index_o         (param_index_o),
    .param_value_o         (param_value_o),
    .good_frame_count_o    (good_frame_count_o),
    .crc_error_count_o     (crc_error_count_o),
    .version_error_count_o (version_error_count_o)
  );

endmodule
